// File: hw/rtl/l2c_pkg.sv
package l2c_pkg;

    localparam int LBA_BITS  = 28;
    localparam int TRK_BITS  = 28;
    localparam int SPT_BITS  = 8;
    localparam int HD_BITS   = 5;
    localparam int CYL_BITS  = 16;

    localparam logic [7:0] CMD_READ_SECTORS  = 8'h20;
    localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;
    localparam logic [7:0] DRIVE_HEAD_BASE   = 8'hA0;
    localparam logic [8:0] COUNT_FULL        = 9'd256;

    localparam logic CFG_SPT   = 1'b0;
    localparam logic CFG_HEADS = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [27:0] lba;
        logic [8:0]  sector_count;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cylinder;
        logic [3:0]  head;
        logic [7:0]  sector;
        logic [7:0]  count_byte;
        logic [7:0]  drive_head_byte;
        logic [7:0]  command_byte;
        logic        range_error;
    } t_out_item;

    // Side data that rides along the divider stages.
    typedef struct packed {
        logic [7:0] count_byte;
        logic [7:0] command_byte;
        logic [4:0] heads;
    } t_side;

endpackage

// File: hw/rtl/l2c_div_stage.sv
// Four restoring steps of the track divider per stage; numerator bits move
// into the remainder and quotient bits shift in at the bottom.
module l2c_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [27:0]         i_num,
    input  logic [7:0]          i_rem,
    input  logic [7:0]          i_spt,
    input  l2c_pkg::t_side      i_side,
    output logic                o_valid,
    output logic [27:0]         o_num,
    output logic [7:0]          o_rem,
    output logic [7:0]          o_spt,
    output l2c_pkg::t_side      o_side
);
    import l2c_pkg::*;

    logic [27:0] n_num;
    logic [7:0]  n_rem;
    logic [8:0]  w;
    logic [27:0] num;
    logic [7:0]  rem;
    logic        r_valid;
    logic [27:0] r_num;
    logic [7:0]  r_rem;
    logic [7:0]  r_spt;
    t_side       r_side;

    // Shift numerator bits into the remainder, quotient bits into the numerator.
    always_comb begin
        num = i_num;
        rem = i_rem;
        for (int k = 0; k < 4; k++) begin
            w   = {rem, num[27]};
            num = {num[26:0], 1'b0};
            if (w >= {1'b0, i_spt}) begin
                rem    = 8'(w - {1'b0, i_spt});
                num[0] = 1'b1;
            end else begin
                rem = w[7:0];
            end
        end
        n_num = num;
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_num  <= n_num;
            r_rem  <= n_rem;
            r_spt  <= i_spt;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_spt   = r_spt;
    assign o_side  = r_side;
endmodule

// File: hw/rtl/l2c_head_split.sv
// Split the track number by the head count: four restoring steps per stage,
// seven stages for all 28 quotient bits; the final remainder is the head.
module l2c_head_split (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic [27:0]         i_num,
    input  logic [4:0]          i_rem,
    input  logic [4:0]          i_div,
    input  logic [7:0]          i_sec,
    input  l2c_pkg::t_side      i_side,
    output logic                o_valid,
    output logic [27:0]         o_num,
    output logic [4:0]          o_rem,
    output logic [4:0]          o_div,
    output logic [7:0]          o_sec,
    output l2c_pkg::t_side      o_side
);
    import l2c_pkg::*;

    logic [27:0] num;
    logic [4:0]  rem;
    logic [5:0]  w;
    logic        r_valid;
    logic [27:0] r_num;
    logic [4:0]  r_rem;
    logic [4:0]  r_div;
    logic [7:0]  r_sec;
    t_side       r_side;

    always_comb begin
        num = i_num;
        rem = i_rem;
        for (int k = 0; k < 4; k++) begin
            w   = {rem, num[27]};
            num = {num[26:0], 1'b0};
            if (w >= {1'b0, i_div}) begin
                rem    = 5'(w - {1'b0, i_div});
                num[0] = 1'b1;
            end else begin
                rem = w[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_num  <= num;
            r_rem  <= rem;
            r_div  <= i_div;
            r_sec  <= i_sec;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_sec   = r_sec;
    assign o_side  = r_side;
endmodule

// File: hw/rtl/lba_to_chs_task_file_top.sv
// Pipeline: 1 entry stage, 7 track divider stages, 7 head divider stages and
// 1 output register lie between input transfer and result.
// Throughput: one command per cycle while the sink does not stall; the two
// restoring dividers, four quotient bits per stage, set the depth.
// Reset: synchronous active low; clears all valid bits and sets sectors per
// track to 63 and heads to 16.
module lba_to_chs_task_file_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  l2c_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output l2c_pkg::t_out_item  o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import l2c_pkg::*;

    localparam int NST = 7;

    logic [7:0]  r_spt;
    logic [4:0]  r_heads;
    logic        adv;

    logic        r_v0;
    logic [27:0] r_lba0;
    logic [7:0]  r_spt0;
    t_side       r_side0;

    logic        tv   [NST+1];
    logic [27:0] tnum [NST+1];
    logic [7:0]  trem [NST+1];
    logic [7:0]  tspt [NST+1];
    t_side       tsd  [NST+1];

    logic        hv   [NST+1];
    logic [27:0] hnum [NST+1];
    logic [4:0]  hrem [NST+1];
    logic [4:0]  hdiv [NST+1];
    logic [7:0]  hsec [NST+1];
    t_side       hsd  [NST+1];

    logic        r_ov;
    t_out_item   r_out;
    t_out_item   n_out;
    logic [7:0]  spt_eff;
    logic [4:0]  hd_eff;

    assign adv         = !(r_ov && i_stall);
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt   <= 8'd63;
            r_heads <= 5'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPT:   r_spt   <= i_cfg_data;
                CFG_HEADS: r_heads <= 5'(i_cfg_data);
                default:   r_spt   <= r_spt;
            endcase
        end
    end

    always_comb begin
        spt_eff = (r_spt == 8'd0) ? 8'd1 : r_spt;
        if (r_heads == 5'd0) begin
            hd_eff = 5'd1;
        end else if (r_heads > 5'd16) begin
            hd_eff = 5'd16;
        end else begin
            hd_eff = r_heads;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
        if (adv) begin
            r_lba0                <= i_data.lba;
            r_spt0                <= spt_eff;
            r_side0.heads         <= hd_eff;
            r_side0.count_byte    <= (i_data.sector_count == COUNT_FULL) ? 8'd0
                                     : i_data.sector_count[7:0];
            r_side0.command_byte  <= i_data.cmd ? CMD_WRITE_SECTORS : CMD_READ_SECTORS;
        end
    end

    assign tv[0]   = r_v0;
    assign tnum[0] = r_lba0;
    assign trem[0] = 8'd0;
    assign tspt[0] = r_spt0;
    assign tsd[0]  = r_side0;

    for (genvar g = 0; g < NST; g++) begin : g_trk
        l2c_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (tv[g]),
            .i_num   (tnum[g]),
            .i_rem   (trem[g]),
            .i_spt   (tspt[g]),
            .i_side  (tsd[g]),
            .o_valid (tv[g+1]),
            .o_num   (tnum[g+1]),
            .o_rem   (trem[g+1]),
            .o_spt   (tspt[g+1]),
            .o_side  (tsd[g+1])
        );
    end

    // Track quotient enters the head divider; sector = remainder + 1.
    assign hv[0]   = tv[NST];
    assign hnum[0] = tnum[NST];
    assign hrem[0] = 5'd0;
    assign hdiv[0] = tsd[NST].heads;
    assign hsec[0] = 8'(trem[NST] + 8'd1);
    assign hsd[0]  = tsd[NST];

    for (genvar g = 0; g < NST; g++) begin : g_hd
        l2c_head_split u_split (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (hv[g]),
            .i_num   (hnum[g]),
            .i_rem   (hrem[g]),
            .i_div   (hdiv[g]),
            .i_sec   (hsec[g]),
            .i_side  (hsd[g]),
            .o_valid (hv[g+1]),
            .o_num   (hnum[g+1]),
            .o_rem   (hrem[g+1]),
            .o_div   (hdiv[g+1]),
            .o_sec   (hsec[g+1]),
            .o_side  (hsd[g+1])
        );
    end

    // lba div (spt*heads) equals (lba div spt) div heads.
    always_comb begin
        n_out.range_error     = (hnum[NST][27:16] != 12'd0);
        n_out.cylinder        = n_out.range_error ? 16'hFFFF : hnum[NST][15:0];
        n_out.head            = hrem[NST][3:0];
        n_out.sector          = hsec[NST];
        n_out.count_byte      = hsd[NST].count_byte;
        n_out.drive_head_byte = DRIVE_HEAD_BASE | {4'd0, hrem[NST][3:0]};
        n_out.command_byte    = hsd[NST].command_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= hv[NST];
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule

// File: bench/tb_lba_to_chs_task_file_top.sv
module tb_lba_to_chs_task_file_top;
    timeunit 1ns;
    timeprecision 1ps;
    import l2c_pkg::*;

    localparam int LATENCY = 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in_item   i_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out_item  o_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_SPT;
    logic [7:0] i_cfg_data = '0;

    lba_to_chs_task_file_top u_top (.*);

    always #5 i_clk = ~i_clk;

    logic [7:0] geom_spt;
    logic [4:0] geom_heads;
    t_out_item  chs_expected[$];
    int         mismatch_count = 0;
    int         cmds_sent = 0;
    int         results_seen = 0;
    int         overflow_seen = 0;
    bit         send_gaps = 1'b1;
    bit         sink_gaps = 1'b1;

    function automatic t_out_item convert_command(t_in_item c);
        t_out_item r;
        logic [31:0] spt;
        logic [31:0] hd;
        logic [31:0] cyl;
        spt = (geom_spt == 0) ? 32'd1 : 32'(geom_spt);
        hd  = (geom_heads == 0) ? 32'd1 : (geom_heads > 16) ? 32'd16 : 32'(geom_heads);
        cyl = 32'(c.lba) / (spt * hd);
        r.range_error = cyl > 65535;
        r.cylinder = r.range_error ? 16'hFFFF : cyl[15:0];
        r.head = 4'((32'(c.lba) / spt) % hd);
        r.sector = 8'((32'(c.lba) % spt) + 1);
        r.count_byte = (c.sector_count == COUNT_FULL) ? 8'd0 : c.sector_count[7:0];
        r.drive_head_byte = DRIVE_HEAD_BASE | {4'd0, r.head};
        r.command_byte = c.cmd ? CMD_WRITE_SECTORS : CMD_READ_SECTORS;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Sink side: random stall, check every transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (chs_expected.size() == 0) begin
                report_mismatch("unexpected result, queue depth", 0, 1);
            end else begin
                e = chs_expected.pop_front();
                if (o_data.range_error) overflow_seen++;
                if (o_data.cylinder != e.cylinder)
                    report_mismatch("cylinder", o_data.cylinder, e.cylinder);
                if (o_data.head != e.head) report_mismatch("head", o_data.head, e.head);
                if (o_data.sector != e.sector)
                    report_mismatch("sector", o_data.sector, e.sector);
                if (o_data.count_byte != e.count_byte)
                    report_mismatch("count_byte", o_data.count_byte, e.count_byte);
                if (o_data.drive_head_byte != e.drive_head_byte)
                    report_mismatch("drive_head_byte", o_data.drive_head_byte,
                                    e.drive_head_byte);
                if (o_data.command_byte != e.command_byte)
                    report_mismatch("command_byte", o_data.command_byte, e.command_byte);
                if (o_data.range_error != e.range_error)
                    report_mismatch("range_error", o_data.range_error, e.range_error);
            end
        end
        i_stall <= sink_gaps && ($urandom_range(99) < 33);
    end

    // Valid stays high after a transfer; drop it only while idling.
    task automatic send_command(t_in_item c);
        if (send_gaps) begin
            while ($urandom_range(99) < 33) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        chs_expected.push_back(convert_command(c));
        cmds_sent++;
    endtask

    task automatic send_fields(bit cmd, logic [27:0] lba, logic [8:0] cnt);
        t_in_item c;
        c.cmd = cmd;
        c.lba = lba;
        c.sector_count = cnt;
        send_command(c);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (chs_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Only while idle: hold the write until the port takes it.
    task automatic write_geometry(logic idx, logic [7:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SPT) geom_spt = val;
        else geom_heads = val[4:0];
        @(posedge i_clk);
    endtask

    task automatic test_reset_geometry();
        send_fields(1'b0, 28'd0, 9'd1);
        send_fields(1'b1, 28'hFFFFFFF, 9'd256);
        send_fields(1'b0, 28'd1007, 9'd255);
        send_fields(1'b1, 28'd1008, 9'd0);
        send_fields(1'b0, 28'h5555555, 9'h1FF);
        send_fields(1'b1, 28'hAAAAAAA, 9'd257);
    endtask

    task automatic test_geometry_extremes();
        write_geometry(CFG_SPT, 8'd1);
        write_geometry(CFG_HEADS, 8'd1);
        send_fields(1'b0, 28'd65535, 9'd2);
        send_fields(1'b1, 28'd65536, 9'd3); // cylinder overflow
        send_fields(1'b0, 28'hFFFFFFF, 9'd128);
        write_geometry(CFG_SPT, 8'd255);
        write_geometry(CFG_HEADS, 8'd16);
        send_fields(1'b1, 28'hFFFFFFF, 9'd256);
        send_fields(1'b0, 28'd4079, 9'd1);
        send_fields(1'b1, 28'd254, 9'd1);
        write_geometry(CFG_SPT, 8'd0);
        write_geometry(CFG_HEADS, 8'd0);
        send_fields(1'b0, 28'd12345, 9'd10);
        send_fields(1'b1, 28'h0FFFFF, 9'd20);
        write_geometry(CFG_SPT, 8'd17);
        write_geometry(CFG_HEADS, 8'd31); // above sixteen clamps to 16
        send_fields(1'b0, 28'hFFFFFFF, 9'd99);
        send_fields(1'b1, 28'd271, 9'd5);
        write_geometry(CFG_HEADS, 8'd17);
        send_fields(1'b0, 28'd272, 9'd6);
    endtask

    task automatic test_random_commands(int n);
        t_in_item c;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) begin
                write_geometry(CFG_SPT, 8'($urandom_range(255)));
                write_geometry(CFG_HEADS, 8'($urandom_range(31)));
            end
            // A stretch with no gaps on either side.
            send_gaps = !(i >= 200 && i < 260);
            sink_gaps = send_gaps;
            c.cmd = 1'($urandom);
            c.lba = 28'($urandom);
            if ($urandom_range(3) == 0) c.lba = c.lba >> $urandom_range(27);
            c.sector_count = ($urandom_range(9) == 0) ? 9'($urandom)
                                                      : 9'($urandom_range(256, 1));
            send_command(c);
        end
        send_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    initial begin
        geom_spt = 8'd63;
        geom_heads = 5'd16;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_geometry_extremes();
        test_random_commands(400);
        drain_results();
        $display("Sent %0d commands, checked %0d results, %0d with range error.",
                 cmds_sent, results_seen, overflow_seen);
        $display("Geometry covered 0..255 sectors per track and 0..31 heads.");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
